### design/vng_pkg.sv
// shared constants, codes and control/status types of the vertex normal generator
package vng_pkg;

  localparam int unsigned VNG_VERTEX_COUNT = 1024;
  localparam int unsigned VNG_COORD_WIDTH  = 16;
  localparam int unsigned VNG_SUM_WIDTH    = 48;

  localparam int unsigned VIDX_W  = 10;
  localparam int unsigned OUT_W   = 16;
  localparam int unsigned NORM_W  = 24;
  localparam int unsigned SQ_W    = 50;
  localparam int unsigned ROOT_W  = 25;
  localparam int unsigned SQREM_W = 27;
  localparam int unsigned QUO_W   = 15;
  localparam int unsigned FRAC_W  = 14;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_TRI  = 2'd1,
    CMD_READ = 2'd2
  } item_cmd_e;

  typedef enum logic [1:0] {
    SEL_A,
    SEL_B,
    SEL_C,
    SEL_CLR
  } vsel_e;

  typedef enum logic [1:0] {
    EDGE_NONE,
    EDGE_A,
    EDGE_E1,
    EDGE_E2
  } edge_op_e;

  typedef enum logic [1:0] {
    WSRC_ZERO,
    WSRC_FACE,
    WSRC_ACC
  } wsrc_e;

  // multiplier operand pairs
  localparam logic [3:0] OP_NX_P = 4'd0;
  localparam logic [3:0] OP_NX_Q = 4'd1;
  localparam logic [3:0] OP_NY_P = 4'd2;
  localparam logic [3:0] OP_NY_Q = 4'd3;
  localparam logic [3:0] OP_NZ_P = 4'd4;
  localparam logic [3:0] OP_NZ_Q = 4'd5;
  localparam logic [3:0] OP_SQ_X = 4'd6;
  localparam logic [3:0] OP_SQ_Y = 4'd7;
  localparam logic [3:0] OP_SQ_Z = 4'd8;

  typedef struct packed {
    logic       capture;
    vsel_e      vsel;
    logic       pos_we;
    logic       pos_rd;
    edge_op_e   edge_op;
    logic       mul_en;
    logic [3:0] mul_sel;
    logic       acc_en;
    logic [3:0] acc_sel;
    logic       sum_rd;
    logic       sum_we;
    wsrc_e      wsrc;
    logic       clr_step;
    logic       mag_load;
    logic       norm_step;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       res_store;
    logic [1:0] comp;
    logic       out_load;
    logic       out_deg;
  } vng_ctrl_t;

  typedef struct packed {
    logic [1:0] item_cmd;
    logic       a_ok;
    logic       tri_ok;
    logic       clr_last;
    logic       norm_zero;
    logic       norm_done;
  } vng_sts_t;

endpackage

### design/vng_if.sv
// channel interfaces: input items, result items and the configuration write
interface vng_in_if #(
  parameter int unsigned COORD_WIDTH = 16
);
  import vng_pkg::*;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    cmd;
  logic [VIDX_W-1:0]             vertex_a;
  logic [VIDX_W-1:0]             vertex_b;
  logic [VIDX_W-1:0]             vertex_c;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [COORD_WIDTH-1:0] pos_z;
  modport source (output valid, cmd, vertex_a, vertex_b, vertex_c, pos_x, pos_y, pos_z,
                  input ready);
  modport sink (input valid, cmd, vertex_a, vertex_b, vertex_c, pos_x, pos_y, pos_z,
                output ready);
endinterface

interface vng_out_if;
  import vng_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] normal_x;
  logic signed [OUT_W-1:0] normal_y;
  logic signed [OUT_W-1:0] normal_z;
  logic                    degenerate;
  modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

interface vng_cfg_if;
  logic valid;
  logic ready;
  logic flat_mode;
  modport source (output valid, flat_mode, input ready);
  modport sink (input valid, flat_mode, output ready);
endinterface

### design/vng_dp.sv
// datapath: vertex memories, cross product, normalization, square root and divider
module vng_dp #(
  parameter int unsigned VERTEX_COUNT = vng_pkg::VNG_VERTEX_COUNT,
  parameter int unsigned COORD_WIDTH  = vng_pkg::VNG_COORD_WIDTH,
  parameter int unsigned SUM_WIDTH    = vng_pkg::VNG_SUM_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  vng_pkg::vng_ctrl_t                ctrl_i,
  output vng_pkg::vng_sts_t                 sts_o,
  input  logic [1:0]                        cmd_i,
  input  logic [vng_pkg::VIDX_W-1:0]        vertex_a_i,
  input  logic [vng_pkg::VIDX_W-1:0]        vertex_b_i,
  input  logic [vng_pkg::VIDX_W-1:0]        vertex_c_i,
  input  logic signed [COORD_WIDTH-1:0]     pos_x_i,
  input  logic signed [COORD_WIDTH-1:0]     pos_y_i,
  input  logic signed [COORD_WIDTH-1:0]     pos_z_i,
  output logic signed [vng_pkg::OUT_W-1:0]  normal_x_o,
  output logic signed [vng_pkg::OUT_W-1:0]  normal_y_o,
  output logic signed [vng_pkg::OUT_W-1:0]  normal_z_o,
  output logic                              degenerate_o
);
  import vng_pkg::*;

  localparam int unsigned AW   = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned SW   = SUM_WIDTH;
  localparam int unsigned EW   = CW + 1;
  localparam int unsigned MW   = (EW > NORM_W + 1) ? EW : NORM_W + 1;
  localparam int unsigned PW   = 2 * MW;
  localparam int unsigned DW   = PW + 1;
  localparam int unsigned XW   = ((DW > SW) ? DW : SW) + 1;
  localparam int unsigned NUMW = NORM_W + FRAC_W + 1;

  function automatic logic signed [SW-1:0] sat_diff(input logic signed [DW-1:0] d);
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] hi;
    logic signed [XW-1:0] lo;
    x  = XW'(d);
    hi = XW'($signed({1'b0, {(SW-1){1'b1}}}));
    lo = XW'($signed({1'b1, {(SW-1){1'b0}}}));
    if (x > hi) begin
      return hi[SW-1:0];
    end else if (x < lo) begin
      return lo[SW-1:0];
    end
    return x[SW-1:0];
  endfunction

  function automatic logic signed [SW-1:0] sat_add(input logic signed [SW-1:0] a,
                                                   input logic signed [SW-1:0] b);
    logic signed [SW:0] s;
    s = (SW+1)'(a) + (SW+1)'(b);
    if (s[SW] != s[SW-1]) begin
      return s[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end
    return s[SW-1:0];
  endfunction

  // captured item
  logic [1:0]        icmd_q;
  logic [VIDX_W-1:0] va_q, vb_q, vc_q;
  logic [3*CW-1:0]   ipos_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      icmd_q <= cmd_i;
      va_q   <= vertex_a_i;
      vb_q   <= vertex_b_i;
      vc_q   <= vertex_c_i;
      ipos_q <= {pos_z_i, pos_y_i, pos_x_i};
    end
  end

  logic a_ok, b_ok, c_ok;
  assign a_ok = 32'(va_q) < VERTEX_COUNT;
  assign b_ok = 32'(vb_q) < VERTEX_COUNT;
  assign c_ok = 32'(vc_q) < VERTEX_COUNT;

  // clearing pass counter
  logic [AW-1:0] clr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (ctrl_i.clr_step) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  logic [AW-1:0] addr;
  always_comb begin
    case (ctrl_i.vsel)
      SEL_A:   addr = AW'(va_q);
      SEL_B:   addr = AW'(vb_q);
      SEL_C:   addr = AW'(vc_q);
      default: addr = clr_q;
    endcase
  end

  // position memory
  logic [3*CW-1:0] pos_mem [VERTEX_COUNT];
  logic [3*CW-1:0] pos_rd_q;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.pos_we) begin
      pos_mem[addr] <= ipos_q;
    end
    if (ctrl_i.pos_rd) begin
      pos_rd_q <= pos_mem[addr];
    end
  end

  logic signed [CW-1:0] prd [3];
  logic signed [CW-1:0] pa_q [3];
  logic signed [EW-1:0] e1_q [3];
  logic signed [EW-1:0] e2_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prd[i] = pos_rd_q[i*CW +: CW];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      case (ctrl_i.edge_op)
        EDGE_A:  pa_q[i] <= prd[i];
        EDGE_E1: e1_q[i] <= EW'(prd[i]) - EW'(pa_q[i]);
        EDGE_E2: e2_q[i] <= EW'(prd[i]) - EW'(pa_q[i]);
        default: ;
      endcase
    end
  end

  // shared multiplier
  logic [SW-1:0]        mag_q [3];
  logic                 neg_q [3];
  logic signed [MW-1:0] ma, mb;
  logic signed [PW-1:0] prod_q;
  logic signed [PW-1:0] first_q;
  logic signed [SW-1:0] n_q [3];
  logic [SQ_W-1:0]      sq_q;

  always_comb begin
    case (ctrl_i.mul_sel)
      OP_NX_P: begin ma = MW'(e1_q[1]); mb = MW'(e2_q[2]); end
      OP_NX_Q: begin ma = MW'(e1_q[2]); mb = MW'(e2_q[1]); end
      OP_NY_P: begin ma = MW'(e1_q[2]); mb = MW'(e2_q[0]); end
      OP_NY_Q: begin ma = MW'(e1_q[0]); mb = MW'(e2_q[2]); end
      OP_NZ_P: begin ma = MW'(e1_q[0]); mb = MW'(e2_q[1]); end
      OP_NZ_Q: begin ma = MW'(e1_q[1]); mb = MW'(e2_q[0]); end
      OP_SQ_X: begin
        ma = $signed(MW'(mag_q[0][NORM_W-1:0]));
        mb = ma;
      end
      OP_SQ_Y: begin
        ma = $signed(MW'(mag_q[1][NORM_W-1:0]));
        mb = ma;
      end
      OP_SQ_Z: begin
        ma = $signed(MW'(mag_q[2][NORM_W-1:0]));
        mb = ma;
      end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  logic signed [DW-1:0] diff;
  assign diff = DW'(first_q) - DW'(prod_q);

  // square root state
  logic [ROOT_W-1:0]  root_q;
  logic [SQREM_W-1:0] sqrem_q;
  logic [SQREM_W+1:0] sq_r2;
  logic [SQREM_W+1:0] sq_trial;
  logic               sq_ge;
  logic [SQREM_W+1:0] sq_sub;

  assign sq_r2    = {sqrem_q, sq_q[SQ_W-1 -: 2]};
  assign sq_trial = (SQREM_W+2)'({root_q, 2'b01});
  assign sq_ge    = sq_r2 >= sq_trial;
  assign sq_sub   = sq_r2 - sq_trial;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= ma * mb;
    end
    if (ctrl_i.acc_en) begin
      case (ctrl_i.acc_sel)
        OP_NX_P, OP_NY_P, OP_NZ_P: first_q <= prod_q;
        OP_NX_Q: n_q[0] <= sat_diff(diff);
        OP_NY_Q: n_q[1] <= sat_diff(diff);
        OP_NZ_Q: n_q[2] <= sat_diff(diff);
        OP_SQ_X: sq_q <= prod_q[SQ_W-1:0];
        OP_SQ_Y, OP_SQ_Z: sq_q <= sq_q + prod_q[SQ_W-1:0];
        default: ;
      endcase
    end else if (ctrl_i.sqrt_step) begin
      sq_q <= {sq_q[SQ_W-3:0], 2'b00};
    end
    if (ctrl_i.sqrt_init) begin
      root_q  <= '0;
      sqrem_q <= '0;
    end else if (ctrl_i.sqrt_step) begin
      root_q  <= {root_q[ROOT_W-2:0], sq_ge};
      sqrem_q <= sq_ge ? sq_sub[SQREM_W-1:0] : sq_r2[SQREM_W-1:0];
    end
  end

  // normal sum memory
  logic [3*SW-1:0]      sum_mem [VERTEX_COUNT];
  logic [3*SW-1:0]      sum_rd_q;
  logic signed [SW-1:0] srd [3];
  logic [3*SW-1:0]      sum_wd;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      srd[i] = sum_rd_q[i*SW +: SW];
    end
    case (ctrl_i.wsrc)
      WSRC_FACE: sum_wd = {n_q[2], n_q[1], n_q[0]};
      WSRC_ACC: sum_wd = {sat_add(srd[2], n_q[2]), sat_add(srd[1], n_q[1]),
                          sat_add(srd[0], n_q[0])};
      default: sum_wd = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sum_we) begin
      sum_mem[addr] <= sum_wd;
    end
    if (ctrl_i.sum_rd) begin
      sum_rd_q <= sum_mem[addr];
    end
  end

  // magnitudes and normalizing shift, one bit a cycle
  logic [SW-1:0] mag_or;
  logic          mag_hi;
  assign mag_or = mag_q[0] | mag_q[1] | mag_q[2];
  assign mag_hi = |mag_or[SW-1:NORM_W];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (ctrl_i.mag_load) begin
        neg_q[i] <= srd[i][SW-1];
        mag_q[i] <= srd[i][SW-1] ? SW'(-srd[i]) : SW'(srd[i]);
      end else if (ctrl_i.norm_step) begin
        mag_q[i] <= mag_hi ? (mag_q[i] >> 1) : (mag_q[i] << 1);
      end
    end
  end

  // divider, one quotient bit a cycle
  logic [NUMW-1:0]   num;
  logic [ROOT_W-1:0] divrem_q;
  logic [QUO_W-1:0]  dq_q;
  logic [ROOT_W:0]   dv_r2;
  logic [ROOT_W:0]   dv_sub;
  logic              dv_ge;
  logic signed [OUT_W-1:0] res_q [3];
  logic [OUT_W-1:0]  qext;

  assign num    = NUMW'({mag_q[ctrl_i.comp][NORM_W-1:0], FRAC_W'(0)}) + NUMW'(root_q >> 1);
  assign dv_r2  = {divrem_q, dq_q[QUO_W-1]};
  assign dv_ge  = dv_r2 >= {1'b0, root_q};
  assign dv_sub = dv_r2 - {1'b0, root_q};
  assign qext   = OUT_W'(dq_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_init) begin
      divrem_q <= ROOT_W'(num[NUMW-1:QUO_W]);
      dq_q     <= num[QUO_W-1:0];
    end else if (ctrl_i.div_step) begin
      divrem_q <= dv_ge ? dv_sub[ROOT_W-1:0] : dv_r2[ROOT_W-1:0];
      dq_q     <= {dq_q[QUO_W-2:0], dv_ge};
    end
    if (ctrl_i.res_store) begin
      res_q[ctrl_i.comp] <= neg_q[ctrl_i.comp] ? -qext : qext;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      normal_x_o   <= ctrl_i.out_deg ? '0 : res_q[0];
      normal_y_o   <= ctrl_i.out_deg ? '0 : res_q[1];
      normal_z_o   <= ctrl_i.out_deg ? '0 : res_q[2];
      degenerate_o <= ctrl_i.out_deg;
    end
  end

  always_comb begin
    sts_o.item_cmd  = icmd_q;
    sts_o.a_ok      = a_ok;
    sts_o.tri_ok    = a_ok && b_ok && c_ok;
    sts_o.clr_last  = clr_q == AW'(VERTEX_COUNT - 1);
    sts_o.norm_zero = mag_or == '0;
    sts_o.norm_done = !mag_hi && mag_or[NORM_W-1];
  end

`ifndef SYNTH
  a_norm_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.norm_step |-> mag_or != '0)
    else $error("normalizing shift on a zero sum");
  a_div_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.div_step |-> divrem_q < root_q)
    else $error("divider remainder not below divisor");
  a_clr_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.clr_step |-> ctrl_i.sum_we && ctrl_i.wsrc == WSRC_ZERO)
    else $error("clearing step without zero write");
`endif

endmodule

### design/vng_ctrl.sv
// controller: item sequencing, clearing pass, configuration and output handshake
module vng_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_flat_mode_i,
  input  vng_pkg::vng_sts_t  sts_i,
  output vng_pkg::vng_ctrl_t ctrl_o
);
  import vng_pkg::*;

  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_DEC   = 5'd2;
  localparam logic [4:0] S_RA    = 5'd3;
  localparam logic [4:0] S_RB    = 5'd4;
  localparam logic [4:0] S_RC    = 5'd5;
  localparam logic [4:0] S_E2    = 5'd6;
  localparam logic [4:0] S_MUL   = 5'd7;
  localparam logic [4:0] S_SRD   = 5'd8;
  localparam logic [4:0] S_SWR   = 5'd9;
  localparam logic [4:0] S_FLAT  = 5'd10;
  localparam logic [4:0] S_RRD   = 5'd11;
  localparam logic [4:0] S_RMAG  = 5'd12;
  localparam logic [4:0] S_NORM  = 5'd13;
  localparam logic [4:0] S_SQ    = 5'd14;
  localparam logic [4:0] S_SQRT  = 5'd15;
  localparam logic [4:0] S_DIV   = 5'd16;
  localparam logic [4:0] S_OUT   = 5'd17;

  localparam logic [4:0] MUL_LAST  = 5'd6;
  localparam logic [4:0] SQ_LAST   = 5'd3;
  localparam logic [4:0] SQRT_LAST = 5'd24;
  localparam logic [4:0] DIV_STORE = 5'd16;
  localparam logic [4:0] CORNER_C  = 5'd2;
  localparam logic [1:0] COMP_Z    = 2'd2;

  logic [4:0] state_q, state_d;
  logic [4:0] k_q, k_d;
  logic [1:0] comp_q, comp_d;
  logic       deg_q, deg_d;
  logic       flat_q;
  logic       out_valid_q, out_valid_d;

  function automatic vsel_e corner(input logic [4:0] k);
    case (k)
      5'd0:    return SEL_A;
      5'd1:    return SEL_B;
      default: return SEL_C;
    endcase
  endfunction

  assign in_ready_o  = state_q == S_IDLE;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    comp_d  = comp_q;
    deg_d   = deg_q;
    ctrl_o  = '0;
    ctrl_o.comp = comp_q;
    case (state_q)
      S_CLEAR: begin
        ctrl_o.clr_step = 1'b1;
        ctrl_o.sum_we   = 1'b1;
        ctrl_o.vsel     = SEL_CLR;
        ctrl_o.wsrc     = WSRC_ZERO;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.capture = 1'b1;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        k_d     = '0;
        state_d = S_IDLE;
        case (sts_i.item_cmd)
          CMD_LOAD: begin
            if (sts_i.a_ok) begin
              ctrl_o.vsel   = SEL_A;
              ctrl_o.pos_we = 1'b1;
              ctrl_o.sum_we = 1'b1;
              ctrl_o.wsrc   = WSRC_ZERO;
            end
          end
          CMD_TRI: begin
            if (sts_i.tri_ok) begin
              state_d = S_RA;
            end
          end
          CMD_READ: begin
            if (sts_i.a_ok) begin
              state_d = S_RRD;
            end else begin
              deg_d   = 1'b1;
              state_d = S_OUT;
            end
          end
          default: ;
        endcase
      end
      S_RA: begin
        ctrl_o.vsel   = SEL_A;
        ctrl_o.pos_rd = 1'b1;
        state_d = S_RB;
      end
      S_RB: begin
        ctrl_o.vsel    = SEL_B;
        ctrl_o.pos_rd  = 1'b1;
        ctrl_o.edge_op = EDGE_A;
        state_d = S_RC;
      end
      S_RC: begin
        ctrl_o.vsel    = SEL_C;
        ctrl_o.pos_rd  = 1'b1;
        ctrl_o.edge_op = EDGE_E1;
        state_d = S_E2;
      end
      S_E2: begin
        ctrl_o.edge_op = EDGE_E2;
        state_d = S_MUL;
      end
      S_MUL: begin
        ctrl_o.mul_en  = k_q < MUL_LAST;
        ctrl_o.mul_sel = 4'(k_q);
        ctrl_o.acc_en  = k_q != '0;
        ctrl_o.acc_sel = 4'(k_q - 5'd1);
        k_d = k_q + 5'd1;
        if (k_q == MUL_LAST) begin
          k_d     = '0;
          state_d = flat_q ? S_FLAT : S_SRD;
        end
      end
      S_SRD: begin
        ctrl_o.vsel   = corner(k_q);
        ctrl_o.sum_rd = 1'b1;
        state_d = S_SWR;
      end
      S_SWR: begin
        ctrl_o.vsel   = corner(k_q);
        ctrl_o.sum_we = 1'b1;
        ctrl_o.wsrc   = WSRC_ACC;
        k_d     = k_q + 5'd1;
        state_d = (k_q == CORNER_C) ? S_IDLE : S_SRD;
      end
      S_FLAT: begin
        ctrl_o.vsel   = corner(k_q);
        ctrl_o.sum_we = 1'b1;
        ctrl_o.wsrc   = WSRC_FACE;
        k_d = k_q + 5'd1;
        if (k_q == CORNER_C) begin
          state_d = S_IDLE;
        end
      end
      S_RRD: begin
        ctrl_o.vsel   = SEL_A;
        ctrl_o.sum_rd = 1'b1;
        state_d = S_RMAG;
      end
      S_RMAG: begin
        ctrl_o.mag_load = 1'b1;
        state_d = S_NORM;
      end
      S_NORM: begin
        if (sts_i.norm_zero) begin
          deg_d   = 1'b1;
          state_d = S_OUT;
        end else if (sts_i.norm_done) begin
          k_d     = '0;
          state_d = S_SQ;
        end else begin
          ctrl_o.norm_step = 1'b1;
        end
      end
      S_SQ: begin
        ctrl_o.sqrt_init = k_q == '0;
        ctrl_o.mul_en    = k_q < SQ_LAST;
        ctrl_o.mul_sel   = OP_SQ_X + 4'(k_q);
        ctrl_o.acc_en    = k_q != '0;
        ctrl_o.acc_sel   = OP_SQ_X + 4'(k_q) - 4'd1;
        k_d = k_q + 5'd1;
        if (k_q == SQ_LAST) begin
          k_d     = '0;
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        ctrl_o.sqrt_step = 1'b1;
        k_d = k_q + 5'd1;
        if (k_q == SQRT_LAST) begin
          k_d     = '0;
          comp_d  = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        ctrl_o.div_init  = k_q == '0;
        ctrl_o.div_step  = (k_q != '0) && (k_q != DIV_STORE);
        ctrl_o.res_store = k_q == DIV_STORE;
        k_d = k_q + 5'd1;
        if (k_q == DIV_STORE) begin
          k_d    = '0;
          comp_d = comp_q + 2'd1;
          if (comp_q == COMP_Z) begin
            deg_d   = 1'b0;
            state_d = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          ctrl_o.out_load = 1'b1;
          ctrl_o.out_deg  = deg_q;
          deg_d   = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      k_q         <= '0;
      comp_q      <= '0;
      deg_q       <= 1'b0;
      flat_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      comp_q      <= comp_d;
      deg_q       <= deg_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        flat_q <= cfg_flat_mode_i;
      end
    end
  end

`ifndef SYNTH
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !in_ready_o)
    else $error("input taken during clearing pass");
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.out_load |-> !out_valid_q || out_ready_i)
    else $error("result overwritten before transfer");
  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_DEC)
    else $error("accepted item not decoded");
`endif

endmodule

### design/vertex_normal_generator.sv
// top level of the vertex normal generator
//
// in_i carries one item per transfer: load a vertex position (clears its
// normal sum), a triangle of three vertex indices, or a readout of one vertex.
// out_o carries one Q1.14 unit normal plus a degenerate flag per readout item.
// cfg_i writes flat_mode and is always ready; the user must write it only
// while idle, which the block does not enforce. Items are handled one at a
// time, ready is high only between items. A triangle uses the single
// multiplier (six products), then in smooth mode one read-modify-write of
// the sum memory per corner; flat mode only writes each corner. A readout
// runs the normalizing shift, the 25-step square root and three divisions;
// an out-of-range readout or a zero sum skips them, flagged degenerate.
// After reset the sum memory is cleared entry by entry while ready
// stays low. A result waits in the output register while the receiver
// stalls; the next item is still taken and processed, and only a second
// readout waits for the register to drain.
module vertex_normal_generator #(
  parameter int unsigned VERTEX_COUNT = vng_pkg::VNG_VERTEX_COUNT,
  parameter int unsigned COORD_WIDTH  = vng_pkg::VNG_COORD_WIDTH,
  parameter int unsigned SUM_WIDTH    = vng_pkg::VNG_SUM_WIDTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  vng_in_if.sink        in_i,
  vng_out_if.source     out_o,
  vng_cfg_if.sink       cfg_i
);
  import vng_pkg::*;

  vng_ctrl_t ctrl;
  vng_sts_t  sts;

  vng_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_i.valid),
    .in_ready_o      (in_i.ready),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .cfg_valid_i     (cfg_i.valid),
    .cfg_ready_o     (cfg_i.ready),
    .cfg_flat_mode_i (cfg_i.flat_mode),
    .sts_i           (sts),
    .ctrl_o          (ctrl)
  );

  vng_dp #(
    .VERTEX_COUNT (VERTEX_COUNT),
    .COORD_WIDTH  (COORD_WIDTH),
    .SUM_WIDTH    (SUM_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .sts_o        (sts),
    .cmd_i        (in_i.cmd),
    .vertex_a_i   (in_i.vertex_a),
    .vertex_b_i   (in_i.vertex_b),
    .vertex_c_i   (in_i.vertex_c),
    .pos_x_i      (in_i.pos_x),
    .pos_y_i      (in_i.pos_y),
    .pos_z_i      (in_i.pos_z),
    .normal_x_o   (out_o.normal_x),
    .normal_y_o   (out_o.normal_y),
    .normal_z_o   (out_o.normal_z),
    .degenerate_o (out_o.degenerate)
  );

endmodule

### tb/tb_top.sv
// testbench for vertex_normal_generator: queued stimulus, predicted normals, checked readouts
`timescale 1ns / 100ps

module tb_top;
  import vng_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 200;

  typedef struct {
    logic [1:0]         cmd;
    logic [VIDX_W-1:0]  va;
    logic [VIDX_W-1:0]  vb;
    logic [VIDX_W-1:0]  vc;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] pz;
  } vng_item_t;

  typedef struct {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               deg;
  } normal_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  vng_in_if #(.COORD_WIDTH(VNG_COORD_WIDTH)) in_if ();
  vng_out_if out_if ();
  vng_cfg_if cfg_if ();

  vertex_normal_generator uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  vng_item_t pending_items[$];
  normal_t   normals_due[$];
  vng_item_t cur_item;
  logic      in_taken = 1'b0;
  int        src_idle_pct = 0;
  int        snk_stall_pct = 0;
  int        errors = 0;

  logic               flat_q = 1'b0;
  logic signed [15:0] pos_x_m[VNG_VERTEX_COUNT];
  logic signed [15:0] pos_y_m[VNG_VERTEX_COUNT];
  logic signed [15:0] pos_z_m[VNG_VERTEX_COUNT];
  longint             sum_x_m[VNG_VERTEX_COUNT];
  longint             sum_y_m[VNG_VERTEX_COUNT];
  longint             sum_z_m[VNG_VERTEX_COUNT];

  bit loaded[VNG_VERTEX_COUNT];
  int loaded_q[$];

  localparam longint SUM_MAX = (64'sd1 <<< (VNG_SUM_WIDTH - 1)) - 1;
  localparam longint SUM_MIN = -SUM_MAX - 1;

  function automatic longint clamp_sum(longint v);
    if (v > SUM_MAX) return SUM_MAX;
    if (v < SUM_MIN) return SUM_MIN;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic normal_t unit_normal(longint sx, longint sy, longint sz);
    normal_t res;
    longint unsigned m[3];
    bit neg[3];
    longint unsigned mx, len, q;
    int bits = 0;
    neg[0] = sx < 0; neg[1] = sy < 0; neg[2] = sz < 0;
    m[0] = neg[0] ? -sx : sx;
    m[1] = neg[1] ? -sy : sy;
    m[2] = neg[2] ? -sz : sz;
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
    res = '{16'sd0, 16'sd0, 16'sd0, 1'b1};
    if (mx == 0) return res;
    while (bits < 64 && (mx >> bits) != 0) bits++;
    for (int i = 0; i < 3; i++)
      m[i] = (bits > 24) ? (m[i] >> (bits - 24)) : (m[i] << (24 - bits));
    len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * 16384 + len / 2) / len;
      if (neg[i]) q = -q;
      case (i)
        0: res.nx = q[15:0];
        1: res.ny = q[15:0];
        default: res.nz = q[15:0];
      endcase
    end
    res.deg = 1'b0;
    return res;
  endfunction

  function automatic void add_face(int v, longint nx, longint ny, longint nz);
    if (flat_q) begin
      sum_x_m[v] = nx; sum_y_m[v] = ny; sum_z_m[v] = nz;
    end else begin
      sum_x_m[v] = clamp_sum(sum_x_m[v] + nx);
      sum_y_m[v] = clamp_sum(sum_y_m[v] + ny);
      sum_z_m[v] = clamp_sum(sum_z_m[v] + nz);
    end
  endfunction

  function automatic void predict_item(vng_item_t it);
    longint e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz;
    case (it.cmd)
      CMD_LOAD: begin
        pos_x_m[it.va] = it.px; pos_y_m[it.va] = it.py; pos_z_m[it.va] = it.pz;
        sum_x_m[it.va] = 0; sum_y_m[it.va] = 0; sum_z_m[it.va] = 0;
      end
      CMD_TRI: begin
        e1x = longint'(pos_x_m[it.vb]) - pos_x_m[it.va];
        e1y = longint'(pos_y_m[it.vb]) - pos_y_m[it.va];
        e1z = longint'(pos_z_m[it.vb]) - pos_z_m[it.va];
        e2x = longint'(pos_x_m[it.vc]) - pos_x_m[it.va];
        e2y = longint'(pos_y_m[it.vc]) - pos_y_m[it.va];
        e2z = longint'(pos_z_m[it.vc]) - pos_z_m[it.va];
        nx = clamp_sum(e1y * e2z - e1z * e2y);
        ny = clamp_sum(e1z * e2x - e1x * e2z);
        nz = clamp_sum(e1x * e2y - e1y * e2x);
        add_face(it.va, nx, ny, nz);
        add_face(it.vb, nx, ny, nz);
        add_face(it.vc, nx, ny, nz);
      end
      CMD_READ: normals_due = {normals_due, unit_normal(sum_x_m[it.va], sum_y_m[it.va],
                                                        sum_z_m[it.va])};
      default: ;
    endcase
  endfunction

  // stimulus builders
  function automatic void push_item(logic [1:0] cmd, int va, int vb, int vc,
                                    int px, int py, int pz);
    vng_item_t it;
    it = '{cmd, va[9:0], vb[9:0], vc[9:0], px[15:0], py[15:0], pz[15:0]};
    if (cmd == CMD_LOAD && !loaded[va]) begin
      loaded[va] = 1'b1;
      loaded_q = {loaded_q, va};
    end
    pending_items = {pending_items, it};
  endfunction

  function automatic int rand_coord(bit tiny);
    return tiny ? $urandom_range(16) - 8 : int'($urandom_range(65535)) - 32768;
  endfunction

  function automatic int pick_loaded(int burst[$]);
    if (burst.size() > 0 && $urandom_range(3) != 0)
      return burst[$urandom_range(burst.size() - 1)];
    return loaded_q[$urandom_range(loaded_q.size() - 1)];
  endfunction

  function automatic void add_random_items(int count);
    int n = 0;
    int burst[$];
    int v, a, b, c;
    bit tiny;
    while (n < count) begin
      if ($urandom_range(9) < 8) begin
        burst = {};
        tiny = $urandom_range(3) == 0;
        repeat ($urandom_range(6, 3)) begin
          v = $urandom_range(1023);
          burst = {burst, v};
          push_item(CMD_LOAD, v, $urandom_range(1023), $urandom_range(1023),
                    rand_coord(tiny), rand_coord(tiny), rand_coord(tiny));
          n++;
        end
        repeat ($urandom_range(6, 2)) begin
          a = pick_loaded(burst); b = pick_loaded(burst); c = pick_loaded(burst);
          if ($urandom_range(9) == 0) b = a;
          push_item(CMD_TRI, a, b, c, rand_coord(0), rand_coord(0), rand_coord(0));
          n++;
        end
        repeat ($urandom_range(3, 1)) begin
          push_item(CMD_READ, pick_loaded(burst), $urandom_range(1023),
                    $urandom_range(1023), rand_coord(0), rand_coord(0), rand_coord(0));
          n++;
        end
      end else begin
        case ($urandom_range(2))
          0: push_item(CMD_NONE, $urandom_range(1023), $urandom_range(1023),
                       $urandom_range(1023), rand_coord(0), rand_coord(0), rand_coord(0));
          1: begin
            push_item(CMD_READ, $urandom_range(1023), $urandom_range(1023),
                      $urandom_range(1023), rand_coord(0), rand_coord(0), rand_coord(0));
            n++;
          end
          default: begin
            push_item(CMD_LOAD, $urandom_range(1023), $urandom_range(1023),
                      $urandom_range(1023), rand_coord(0), rand_coord(0), rand_coord(0));
            n++;
          end
        endcase
      end
    end
  endfunction

  // input driver and output ready
  always @(negedge clk_i) begin
    if (rst_ni && (!in_if.valid || in_taken)) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        cur_item = pending_items.pop_front();
        in_if.cmd      <= cur_item.cmd;
        in_if.vertex_a <= cur_item.va;
        in_if.vertex_b <= cur_item.vb;
        in_if.vertex_c <= cur_item.vc;
        in_if.pos_x    <= cur_item.px;
        in_if.pos_y    <= cur_item.py;
        in_if.pos_z    <= cur_item.pz;
        in_if.valid    <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
    out_if.ready <= rst_ni && ($urandom_range(99) >= snk_stall_pct);
  end

  // transfer monitor
  always @(posedge clk_i) begin
    normal_t want;
    in_taken <= in_if.valid && in_if.ready;
    if (in_if.valid && in_if.ready) predict_item(cur_item);
    if (out_if.valid && out_if.ready) begin
      if (normals_due.size() == 0) begin
        $display("%0t: unexpected normal %0d %0d %0d deg %0b", $time, out_if.normal_x,
                 out_if.normal_y, out_if.normal_z, out_if.degenerate);
        errors++;
      end else begin
        want = normals_due.pop_front();
        if (out_if.normal_x !== want.nx || out_if.normal_y !== want.ny ||
            out_if.normal_z !== want.nz || out_if.degenerate !== want.deg) begin
          $display("%0t: normal mismatch, expected %0d %0d %0d deg %0b, got %0d %0d %0d deg %0b",
                   $time, want.nx, want.ny, want.nz, want.deg, out_if.normal_x,
                   out_if.normal_y, out_if.normal_z, out_if.degenerate);
          errors++;
        end
      end
    end
  end

  task automatic drain();
    while (pending_items.size() > 0 || in_if.valid || normals_due.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_flat(logic v);
    drain();
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.flat_mode <= v;
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
    flat_q = v;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.cmd = CMD_LOAD;
    in_if.vertex_a = '0;
    in_if.vertex_b = '0;
    in_if.vertex_c = '0;
    in_if.pos_x = '0;
    in_if.pos_y = '0;
    in_if.pos_z = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.flat_mode = 1'b0;
    for (int i = 0; i < VNG_VERTEX_COUNT; i++) begin
      pos_x_m[i] = 0; pos_y_m[i] = 0; pos_z_m[i] = 0;
      sum_x_m[i] = 0; sum_y_m[i] = 0; sum_z_m[i] = 0;
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // extremes, repeated corners, zero sums and the ignored command
    push_item(CMD_LOAD, 0, 1023, 1023, -32768, -32768, -32768);
    push_item(CMD_LOAD, 1023, 0, 0, 32767, 32767, 32767);
    push_item(CMD_LOAD, 1, 0, 0, 32767, -32768, 0);
    push_item(CMD_LOAD, 2, 0, 0, -32768, 32767, 32767);
    push_item(CMD_READ, 0, 0, 0, 0, 0, 0);
    push_item(CMD_TRI, 0, 1023, 1, 0, 0, 0);
    push_item(CMD_TRI, 1023, 2, 1, -1, -1, -1);
    push_item(CMD_READ, 0, 1023, 1023, 0, 0, 0);
    push_item(CMD_READ, 1023, 0, 0, 0, 0, 0);
    push_item(CMD_READ, 1, 0, 0, 0, 0, 0);
    push_item(CMD_READ, 2, 0, 0, 0, 0, 0);
    push_item(CMD_TRI, 0, 0, 1, 0, 0, 0);
    push_item(CMD_TRI, 1, 1, 1, 0, 0, 0);
    push_item(CMD_READ, 1, 0, 0, 0, 0, 0);
    push_item(CMD_LOAD, 1, 0, 0, 5, 5, 5);
    push_item(CMD_READ, 1, 0, 0, 0, 0, 0);
    push_item(CMD_READ, 512, 0, 0, 0, 0, 0);
    push_item(CMD_NONE, 1023, 1023, 1023, -1, -1, -1);
    push_item(CMD_LOAD, 3, 0, 0, 0, 0, 0);
    push_item(CMD_LOAD, 4, 0, 0, 1, 0, 0);
    push_item(CMD_LOAD, 5, 0, 0, 0, 1, 0);
    push_item(CMD_TRI, 3, 4, 5, 0, 0, 0);
    push_item(CMD_TRI, 3, 5, 4, 0, 0, 0);
    push_item(CMD_READ, 3, 0, 0, 0, 0, 0);
    push_item(CMD_READ, 4, 0, 0, 0, 0, 0);

    write_flat(1'b1);
    add_random_items(230);
    write_flat(1'b0);
    src_idle_pct = 79;
    add_random_items(230);
    write_flat(1'b1);
    src_idle_pct = 0;
    snk_stall_pct = 79;
    add_random_items(230);
    write_flat(1'b0);
    src_idle_pct = 36;
    snk_stall_pct = 36;
    add_random_items(230);
    drain();

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### sim.f
design/vng_pkg.sv
design/vng_if.sv
design/vng_dp.sv
design/vng_ctrl.sv
design/vertex_normal_generator.sv
tb/tb_top.sv
